// File: hdl/cta_pkg.sv
package cta_pkg;

  // default sizing
  localparam int CTA_TABLE_DEPTH  = 16;
  localparam int CTA_CORDIC_STEPS = 16;

  // fixed field and datapath widths
  localparam int INDEX_W   = 4;
  localparam int CORDIC_XW = 26;  // x, y with 8 extra fraction bits plus cordic growth
  localparam int CORDIC_ZW = 24;  // angle accumulator, 2^-20 rad units
  localparam int ATAN_W    = 20;
  localparam int ACC_W     = 34;  // exact complex product
  localparam int MPROD_W   = CORDIC_XW + 31;

  localparam logic signed [CORDIC_ZW-1:0] PI_UNITS     = 24'sd3294199;
  localparam logic        [29:0]          INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [16:0]          PI_Q13       = 17'sd25736;

  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_MODULUS  = 3'd1,
    CMD_ARGUMENT = 3'd2,
    CMD_SUM      = 3'd3,
    CMD_PRODUCT  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_CORDIC,
    ST_SCALE,
    ST_CPLX,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        [2:0]         command;
    logic        [INDEX_W-1:0] index_a;
    logic        [INDEX_W-1:0] index_b;
    logic signed [15:0]        write_real;
    logic signed [15:0]        write_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result_real;
    logic signed [15:0] result_imag;
    logic        [15:0] magnitude;
    logic signed [15:0] angle;
    logic               zero_operand;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } entry_t;

  // atan(2^-i) in units of 2^-20 rad
  function automatic logic [ATAN_W-1:0] atan_units(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      5'd21:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/complex_table_alu.sv
// from acceptance to result valid: table read, then the cordic loop and gain scaling for a
// modulus, the cordic loop for an argument, the complex unit for sum and product; a zero entry
// skips the loop. throughput: one transaction at a time, set by the iterative cordic loop and
// the shared multiplier; a write or ignored command leaves the block idle, the next one following at once
// reset: control and output valid cleared at once; table entries undefined until written
module complex_table_alu import cta_pkg::*; #(
  parameter int TABLE_DEPTH  = CTA_TABLE_DEPTH,
  parameter int CORDIC_STEPS = CTA_CORDIC_STEPS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  state_t state, state_next;

  logic [2:0] cmd_q;
  logic       zero_q;

  // table interface
  logic   accept;
  logic   is_read;
  logic   wr_en;
  logic   rd_en;
  entry_t rd_a, rd_b;
  entry_t wr_entry;

  // unit handshakes
  logic cordic_start, cordic_done;
  logic cplx_start, cplx_done;
  logic load_out;
  logic a_zero;
  logic q_is_vec;

  logic signed [CORDIC_XW-1:0] cx;
  logic signed [CORDIC_ZW-1:0] cz;
  logic signed [15:0]          c_real, c_imag;
  logic                        c_sat;

  // modulus scaling
  logic signed [MPROD_W-1:0] mag_prod;
  logic signed [26:0]        mag_m;
  logic signed [26:0]        mag_r;
  logic        [15:0]        mag_final;

  // argument rounding
  logic signed [CORDIC_ZW-1:0] z_rnd;
  logic signed [16:0]          ang_a;
  logic signed [15:0]          ang_final;

  out_item_t res;

  assign accept   = in_valid && in_ready;
  assign wr_entry = '{re: in_item.write_real, im: in_item.write_imag};
  assign a_zero   = (rd_a.re == 16'sd0) && (rd_a.im == 16'sd0);
  assign q_is_vec = (cmd_q == CMD_MODULUS) || (cmd_q == CMD_ARGUMENT);

  always_comb begin
    unique case (in_item.command)
      CMD_MODULUS, CMD_ARGUMENT, CMD_SUM, CMD_PRODUCT: is_read = 1'b1;
      default:                                         is_read = 1'b0;
    endcase
  end

  // state register and captured command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= in_item.command;
    end
    if (state == ST_LAUNCH) begin
      zero_q <= a_zero;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && is_read) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (q_is_vec) begin
          state_next = a_zero ? ST_FINISH : ST_CORDIC;
        end else begin
          state_next = ST_CPLX;
        end
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          state_next = (cmd_q == CMD_MODULUS) ? ST_SCALE : ST_FINISH;
        end
      end
      ST_SCALE: state_next = ST_FINISH;
      ST_CPLX: begin
        if (cplx_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready     = (state == ST_IDLE);
    wr_en        = accept && (in_item.command == CMD_WRITE);
    rd_en        = accept && is_read;
    cordic_start = (state == ST_LAUNCH) && q_is_vec && !a_zero;
    cplx_start   = (state == ST_LAUNCH) && !q_is_vec;
    load_out     = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  // write and read never share a cycle, so the table needs no bypass
  cta_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (in_item.index_a),
    .wr_data    (wr_entry),
    .rd_en      (rd_en),
    .rd_index_a (in_item.index_a),
    .rd_index_b (in_item.index_b),
    .rd_data_a  (rd_a),
    .rd_data_b  (rd_b)
  );

  cta_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .re    (rd_a.re),
    .im    (rd_a.im),
    .done  (cordic_done),
    .x_out (cx),
    .z_out (cz)
  );

  cta_cplx u_cplx (
    .clk        (clk),
    .rst        (rst),
    .start      (cplx_start),
    .is_product (cmd_q == CMD_PRODUCT),
    .op_a       (rd_a),
    .op_b       (rd_b),
    .done       (cplx_done),
    .res_real   (c_real),
    .res_imag   (c_imag),
    .sat        (c_sat)
  );

  // gain correction, registered before the rounding step
  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      mag_prod <= cx * $signed({1'b0, INV_GAIN_Q30});
    end
  end

  assign mag_m = mag_prod[MPROD_W-1:30];
  assign mag_r = (mag_m + 27'sd128) >>> 8;

  always_comb begin
    if (mag_r < 0) begin
      mag_final = 16'd0;
    end else if (mag_r > 27'sd65535) begin
      mag_final = 16'hffff;
    end else begin
      mag_final = mag_r[15:0];
    end
  end

  // 2^-20 rad down to q3.13, half up
  assign z_rnd = cz + CORDIC_ZW'(64);
  assign ang_a = z_rnd[CORDIC_ZW-1:7];

  always_comb begin
    if (ang_a > PI_Q13) begin
      ang_final = PI_Q13[15:0];
    end else if (ang_a < -PI_Q13) begin
      ang_final = 16'(-PI_Q13);
    end else begin
      ang_final = ang_a[15:0];
    end
  end

  // fields the command does not produce stay zero
  always_comb begin
    res = '0;
    unique case (cmd_q)
      CMD_MODULUS: begin
        res.magnitude = zero_q ? 16'd0 : mag_final;
      end
      CMD_ARGUMENT: begin
        res.angle        = zero_q ? 16'sd0 : ang_final;
        res.zero_operand = zero_q;
      end
      CMD_SUM, CMD_PRODUCT: begin
        res.result_real = c_real;
        res.result_imag = c_imag;
        res.saturated   = c_sat;
      end
      default: res = '0;
    endcase
  end

  // output register: holds a finished transaction while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item <= res;
    end
  end

endmodule

// File: hdl/cta_table.sv
module cta_table import cta_pkg::*; #(
  parameter int DEPTH = CTA_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [INDEX_W-1:0] wr_index,
  input  entry_t             wr_data,
  input  logic               rd_en,
  input  logic [INDEX_W-1:0] rd_index_a,
  input  logic [INDEX_W-1:0] rd_index_b,
  output entry_t             rd_data_a,
  output entry_t             rd_data_b
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t mem [DEPTH];
  entry_t rd_a;
  entry_t rd_b;
  logic   miss_a;
  logic   miss_b;

  logic wr_ok, ok_a, ok_b;

  // indices past the depth write nothing and read as zero
  assign wr_ok = {5'd0, wr_index}   < 9'(DEPTH);
  assign ok_a  = {5'd0, rd_index_a} < 9'(DEPTH);
  assign ok_b  = {5'd0, rd_index_b} < 9'(DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[AW'(wr_index)] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[AW'(rd_index_a)];
      rd_b <= mem[AW'(rd_index_b)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_a <= 1'b0;
      miss_b <= 1'b0;
    end else if (rd_en) begin
      miss_a <= !ok_a;
      miss_b <= !ok_b;
    end
  end

  assign rd_data_a = miss_a ? '0 : rd_a;
  assign rd_data_b = miss_b ? '0 : rd_b;

endmodule

// File: hdl/cta_cordic.sv
module cta_cordic import cta_pkg::*; #(
  parameter int STEPS = CTA_CORDIC_STEPS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [15:0]          re,
  input  logic signed [15:0]          im,
  output logic                        done,
  output logic signed [CORDIC_XW-1:0] x_out,
  output logic signed [CORDIC_ZW-1:0] z_out
);

  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic signed [CORDIC_XW-1:0] x, y;
  logic signed [CORDIC_ZW-1:0] z;
  logic        [IW-1:0]        step;
  logic                        busy;

  logic signed [CORDIC_XW-1:0] x0, y0, dx, dy;
  logic signed [CORDIC_ZW-1:0] da;

  // operand with 8 more fraction bits
  assign x0 = $signed({{2{re[15]}}, re, 8'd0});
  assign y0 = $signed({{2{im[15]}}, im, 8'd0});

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign da = $signed(CORDIC_ZW'(atan_units(5'(step))));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // left half plane: turn by pi first
      if (re < 0) begin
        x <= -x0;
        y <= -y0;
        z <= (im >= 0) ? PI_UNITS : -PI_UNITS;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end
    end
  end

  assign x_out = x;
  assign z_out = z;

endmodule

// File: hdl/cta_cplx.sv
module cta_cplx import cta_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               is_product,
  input  entry_t             op_a,
  input  entry_t             op_b,
  output logic               done,
  output logic signed [15:0] res_real,
  output logic signed [15:0] res_imag,
  output logic               sat
);

  logic signed [ACC_W-1:0] acc_r, acc_i;
  logic signed [31:0]      prod;
  logic                    mode_prod;
  logic                    issue;
  logic [1:0]              cnt;
  logic                    pvalid;
  logic [1:0]              pstep;

  logic signed [15:0]      mx, my;
  logic signed [ACC_W-1:0] fin_r, fin_i;
  logic                    sat_r, sat_i;

  // partial product order: ar*br, ai*bi, ar*bi, ai*br
  always_comb begin
    unique case (cnt)
      2'd0: begin mx = op_a.re; my = op_b.re; end
      2'd1: begin mx = op_a.im; my = op_b.im; end
      2'd2: begin mx = op_a.re; my = op_b.im; end
      default: begin mx = op_a.im; my = op_b.re; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue  <= 1'b0;
      pvalid <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done   <= 1'b0;
      pvalid <= issue;
      if (start) begin
        issue <= is_product;
        cnt   <= '0;
        done  <= !is_product;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
        if (cnt == 2'd3) begin
          issue <= 1'b0;
        end
      end
      if (pvalid && pstep == 2'd3) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= mx * my;
    pstep <= cnt;
    if (start) begin
      mode_prod <= is_product;
      if (is_product) begin
        acc_r <= '0;
        acc_i <= '0;
      end else begin
        acc_r <= ACC_W'(op_a.re) + ACC_W'(op_b.re);
        acc_i <= ACC_W'(op_a.im) + ACC_W'(op_b.im);
      end
    end else if (pvalid) begin
      unique case (pstep)
        2'd0: acc_r <= acc_r + ACC_W'(prod);
        2'd1: acc_r <= acc_r - ACC_W'(prod);
        default: acc_i <= acc_i + ACC_W'(prod);
      endcase
    end
  end

  // product rounds half up by 2^-8 before clipping
  assign fin_r = mode_prod ? ((acc_r + ACC_W'(128)) >>> 8) : acc_r;
  assign fin_i = mode_prod ? ((acc_i + ACC_W'(128)) >>> 8) : acc_i;

  assign sat_r = (fin_r > ACC_W'(32767)) || (fin_r < -ACC_W'(32768));
  assign sat_i = (fin_i > ACC_W'(32767)) || (fin_i < -ACC_W'(32768));

  always_comb begin
    if (fin_r > ACC_W'(32767)) begin
      res_real = 16'sh7fff;
    end else if (fin_r < -ACC_W'(32768)) begin
      res_real = -16'sh8000;
    end else begin
      res_real = fin_r[15:0];
    end
    if (fin_i > ACC_W'(32767)) begin
      res_imag = 16'sh7fff;
    end else if (fin_i < -ACC_W'(32768)) begin
      res_imag = -16'sh8000;
    end else begin
      res_imag = fin_i[15:0];
    end
  end

  assign sat = sat_r || sat_i;

endmodule
